// File: design/csiesp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csiesp_pkg
// Shared types and constants for the CSI escape sequence parser.
// ----------------------------------------------------------------------------
package csiesp_pkg;

	// Default depth of the parameter list
	localparam int MAX_PARAMS_DEF = 8;

	// Bytes with a meaning of their own
	localparam logic [7:0] CH_ESC     = 8'h1B;
	localparam logic [7:0] CH_LBRACK  = 8'h5B; // '['
	localparam logic [7:0] CH_QMARK   = 8'h3F; // '?'
	localparam logic [7:0] CH_SEMI    = 8'h3B; // ';'
	localparam logic [7:0] CH_ZERO    = 8'h30; // '0'
	localparam logic [7:0] CH_NINE    = 8'h39; // '9'
	localparam logic [7:0] CH_LEFT    = 8'h44; // 'D'
	localparam logic [7:0] CH_RIGHT   = 8'h43; // 'C'
	localparam logic [7:0] CH_CUP     = 8'h48; // 'H'
	localparam logic [7:0] CH_CLEAR   = 8'h4A; // 'J'
	localparam logic [7:0] CH_SET     = 8'h68; // 'h'
	localparam logic [7:0] CH_RESET   = 8'h6C; // 'l'
	localparam logic [7:0] CH_SGR     = 8'h6D; // 'm'

	// Parameter values checked by the decoder
	localparam logic [15:0] MODE_ALT_SCREEN = 16'd1049;
	localparam logic [15:0] SGR_FG_EXT      = 16'd38;
	localparam logic [15:0] COLOR_RGB       = 16'd2;
	localparam logic [15:0] PARAM_SAT       = 16'hFFFF;

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_LEFT      = 3'd1,
		ACT_RIGHT     = 3'd2,
		ACT_SET_CUR   = 3'd3,
		ACT_CLEAR     = 3'd4,
		ACT_ALT_ON    = 3'd5,
		ACT_ALT_OFF   = 3'd6,
		ACT_COLOR     = 3'd7
	} action_t;

	typedef enum logic [3:0] {
		WARN_NONE            = 4'd0,
		WARN_CUP_ARGS        = 4'd1,
		WARN_MODE_NO_CODE    = 4'd2,
		WARN_UNKNOWN_MODE    = 4'd3,
		WARN_NO_COLOR_TYPE   = 4'd4,
		WARN_BAD_COLOR_TYPE  = 4'd5,
		WARN_BAD_COLOR_COUNT = 4'd6,
		WARN_UNKNOWN_SGR     = 4'd7,
		WARN_UNKNOWN_FINAL   = 4'd8
	} warning_t;

	typedef struct packed {
		logic        consumed;
		action_t     action;
		warning_t    warning;
		logic        screen_select;
		logic [15:0] arg_a;
		logic [15:0] arg_b;
		logic [15:0] arg_c;
	} result_t;

	// Scalar parser state handed between decoder and state registers
	typedef struct packed {
		logic        in_seq;
		logic        alt;
		logic [15:0] running;
	} flags_t;

endpackage
`default_nettype wire

// File: design/csiesp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csiesp_in_if / csiesp_out_if
// Valid/ready channels for console bytes in and parse results out.
// ----------------------------------------------------------------------------
interface csiesp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink   (input valid, input byte_in, output ready);
endinterface

interface csiesp_out_if;
	logic                 valid;
	logic                 ready;
	logic                 consumed;
	csiesp_pkg::action_t  action;
	csiesp_pkg::warning_t warning;
	logic                 screen_select;
	logic [15:0]          arg_a;
	logic [15:0]          arg_b;
	logic [15:0]          arg_c;

	modport source (output valid, output consumed, output action, output warning,
		output screen_select, output arg_a, output arg_b, output arg_c, input ready);
	modport sink   (input valid, input consumed, input action, input warning,
		input screen_select, input arg_a, input arg_b, input arg_c, output ready);
endinterface
`default_nettype wire

// File: design/csiesp_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csiesp_decode
// Combinational decode of one byte against the current parser state.
// ----------------------------------------------------------------------------
module csiesp_decode #(
	parameter int MAX_PARAMS = csiesp_pkg::MAX_PARAMS_DEF,
	localparam int CW = $clog2(MAX_PARAMS + 1)
) (
	input  wire logic [7:0]         byte_in,
	input  wire csiesp_pkg::flags_t cur,
	input  wire logic [CW-1:0]      count,
	input  wire logic [15:0]        store [MAX_PARAMS],
	output      csiesp_pkg::flags_t nxt,
	output      logic [CW-1:0]      nxt_count,
	output      logic               push_en,
	output      csiesp_pkg::result_t res
);

	logic          push_ok;
	logic [CW-1:0] cnt_f;
	logic [15:0]   p0, p1, p2, p3, p4;
	logic [19:0]   acc;

	// Entries as seen after the closing push of the running parameter
	assign push_ok = (count < CW'(MAX_PARAMS));
	assign cnt_f   = push_ok ? count + CW'(1) : count;
	assign p0 = (push_ok && count == CW'(0)) ? cur.running : store[0];
	assign p1 = (push_ok && count == CW'(1)) ? cur.running : store[1];
	assign p2 = (push_ok && count == CW'(2)) ? cur.running : store[2];
	assign p3 = (push_ok && count == CW'(3)) ? cur.running : store[3];
	assign p4 = (push_ok && count == CW'(4)) ? cur.running : store[4];

	// running * 10 + digit
	assign acc = ({4'd0, cur.running} << 3) + ({4'd0, cur.running} << 1)
		+ {16'd0, byte_in[3:0]};

	always_comb begin
		nxt       = cur;
		nxt_count = count;
		push_en   = 1'b0;
		res.consumed      = 1'b1;
		res.action        = csiesp_pkg::ACT_NONE;
		res.warning       = csiesp_pkg::WARN_NONE;
		res.arg_a         = 16'd0;
		res.arg_b         = 16'd0;
		res.arg_c         = 16'd0;

		if (byte_in == csiesp_pkg::CH_ESC) begin
			nxt.in_seq  = 1'b1;
			nxt.running = 16'd0;
			nxt_count   = CW'(0);
		end else if (!cur.in_seq) begin
			res.consumed = 1'b0;
		end else if (byte_in == csiesp_pkg::CH_LBRACK || byte_in == csiesp_pkg::CH_QMARK) begin
			// skip intermediate bytes
		end else if (byte_in >= csiesp_pkg::CH_ZERO && byte_in <= csiesp_pkg::CH_NINE) begin
			nxt.running = (acc > {4'd0, csiesp_pkg::PARAM_SAT}) ? csiesp_pkg::PARAM_SAT
				: acc[15:0];
		end else if (byte_in == csiesp_pkg::CH_SEMI) begin
			push_en     = push_ok;
			nxt_count   = cnt_f;
			nxt.running = 16'd0;
		end else begin
			push_en     = push_ok;
			nxt_count   = cnt_f;
			nxt.running = 16'd0;
			nxt.in_seq  = 1'b0;
			case (byte_in)
				csiesp_pkg::CH_LEFT:  res.action = csiesp_pkg::ACT_LEFT;
				csiesp_pkg::CH_RIGHT: res.action = csiesp_pkg::ACT_RIGHT;
				csiesp_pkg::CH_CLEAR: res.action = csiesp_pkg::ACT_CLEAR;
				csiesp_pkg::CH_CUP: begin
					if (cnt_f != CW'(2)) begin
						res.warning = csiesp_pkg::WARN_CUP_ARGS;
					end else begin
						res.action = csiesp_pkg::ACT_SET_CUR;
						res.arg_a  = p1;
						res.arg_b  = p0;
					end
				end
				csiesp_pkg::CH_SET, csiesp_pkg::CH_RESET: begin
					if (cnt_f != CW'(1)) begin
						res.warning = csiesp_pkg::WARN_MODE_NO_CODE;
					end else if (p0 != csiesp_pkg::MODE_ALT_SCREEN) begin
						res.warning = csiesp_pkg::WARN_UNKNOWN_MODE;
					end else if (byte_in == csiesp_pkg::CH_SET) begin
						nxt.alt    = 1'b1;
						res.action = csiesp_pkg::ACT_ALT_ON;
					end else begin
						nxt.alt    = 1'b0;
						res.action = csiesp_pkg::ACT_ALT_OFF;
					end
				end
				csiesp_pkg::CH_SGR: begin
					if (p0 != csiesp_pkg::SGR_FG_EXT) begin
						res.warning = csiesp_pkg::WARN_UNKNOWN_SGR;
					end else if (cnt_f < CW'(2)) begin
						res.warning = csiesp_pkg::WARN_NO_COLOR_TYPE;
					end else if (p1 != csiesp_pkg::COLOR_RGB) begin
						res.warning = csiesp_pkg::WARN_BAD_COLOR_TYPE;
					end else if (cnt_f != CW'(5)) begin
						res.warning = csiesp_pkg::WARN_BAD_COLOR_COUNT;
					end else begin
						res.action = csiesp_pkg::ACT_COLOR;
						res.arg_a  = p2;
						res.arg_b  = p3;
						res.arg_c  = p4;
					end
				end
				default: res.warning = csiesp_pkg::WARN_UNKNOWN_FINAL;
			endcase
		end
		res.screen_select = nxt.alt;
	end

endmodule
`default_nettype wire

// File: design/csi_escape_sequence_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csi_escape_sequence_parser_core
// Byte-serial ANSI CSI parser: one console byte in, one parse result out.
// ----------------------------------------------------------------------------
// Every accepted byte yields exactly one result beat, in order. The block takes
// one byte per clock cycle for as long as results are drained. A byte is
// captured in the input register when it is accepted and reaches the result
// register when the decode stage advances, which waits while a result is held
// unread (combinational decode against the parser state in between). The
// decode step updates the escape flag, the running decimal parameter, the
// parameter list and the screen bit in the same cycle it produces the result.
// The result register lets a new byte enter while an earlier result still
// waits on the output side. No clearing pass is needed after reset: list
// entries are only read below the fill count.
// ----------------------------------------------------------------------------
module csi_escape_sequence_parser_core #(
	parameter int MAX_PARAMS = csiesp_pkg::MAX_PARAMS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	csiesp_in_if.sink   in_ch,
	csiesp_out_if.source out_ch
);

	localparam int CW = $clog2(MAX_PARAMS + 1);
	localparam int IW = $clog2(MAX_PARAMS);

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state
	csiesp_pkg::flags_t flags_q;
	logic [CW-1:0]      count_q;
	logic [15:0]        store_q [MAX_PARAMS];

	// Result register
	logic                valid_q;
	csiesp_pkg::result_t res_q;

	// Decoder outputs
	csiesp_pkg::flags_t  flags_nxt;
	logic [CW-1:0]       count_nxt;
	logic                push_en;
	csiesp_pkg::result_t res_nxt;

	logic adv;

	// Advance the decode stage whenever the result register is free or draining
	assign adv          = valid_s1 && (!valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || adv;

	csiesp_decode #(
		.MAX_PARAMS(MAX_PARAMS)
	) u_decode (
		.byte_in   (byte_s1),
		.cur       (flags_q),
		.count     (count_q),
		.store     (store_q),
		.nxt       (flags_nxt),
		.nxt_count (count_nxt),
		.push_en   (push_en),
		.res       (res_nxt)
	);

	// Input register: load on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.byte_in;
		end
	end

	// Parser state: commit only when the byte leaves the decode stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			count_q <= '0;
		end else if (adv) begin
			flags_q <= flags_nxt;
			count_q <= count_nxt;
		end
	end

	// Parameter list: push the running parameter at the fill position
	always_ff @(posedge clk) begin
		if (adv && push_en) begin
			store_q[count_q[IW-1:0]] <= flags_q.running;
		end
	end

	// Result register: hold until the sink takes the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	// Drive the result channel
	assign out_ch.valid         = valid_q;
	assign out_ch.consumed      = res_q.consumed;
	assign out_ch.action        = res_q.action;
	assign out_ch.warning       = res_q.warning;
	assign out_ch.screen_select = res_q.screen_select;
	assign out_ch.arg_a         = res_q.arg_a;
	assign out_ch.arg_b         = res_q.arg_b;
	assign out_ch.arg_c         = res_q.arg_c;

endmodule
`default_nettype wire
